/* src/oxc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oxc_pkg
// Shared types and constants for the ordered crossover block.
// ----------------------------------------------------------------------------
package oxc_pkg;

  localparam int CLIENT_W = 7;
  localparam int SLICE_W  = 6;
  localparam int NCFG_W   = 7;

  localparam logic [NCFG_W-1:0] N_CLIENTS_RESET = 7'd64;

  typedef logic [CLIENT_W-1:0] client_t;
  typedef logic [SLICE_W-1:0]  slice_t;
  typedef logic [NCFG_W-1:0]   ncfg_t;

  typedef struct packed {
    client_t b;
    client_t a;
  } tour_pair_t;

  typedef struct packed {
    logic    clr;
    logic    wr_en;
    client_t wr_data;
  } child_ctl_t;

endpackage

/* src/oxc_tour_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oxc_tour_mem
// Storage for both parent tours, one entry per position, registered read.
// ----------------------------------------------------------------------------
module oxc_tour_mem #(
  parameter int MAX_CLIENTS = 64
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(MAX_CLIENTS)-1:0] wr_addr,
  input  oxc_pkg::tour_pair_t            wr_data,
  input  logic [$clog2(MAX_CLIENTS)-1:0] rd_addr,
  output oxc_pkg::tour_pair_t            rd_data
);

  oxc_pkg::tour_pair_t mem [MAX_CLIENTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/oxc_child_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oxc_child_mem
// Child tour storage with one valid bit per slot; unwritten slots read zero.
// ----------------------------------------------------------------------------
module oxc_child_mem #(
  parameter int MAX_CLIENTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  oxc_pkg::child_ctl_t            ctl,
  input  logic [$clog2(MAX_CLIENTS)-1:0] wr_addr,
  input  logic [$clog2(MAX_CLIENTS)-1:0] rd_addr,
  output oxc_pkg::client_t               rd_data
);

  oxc_pkg::client_t       mem [MAX_CLIENTS];
  logic [MAX_CLIENTS-1:0] valid;
  oxc_pkg::client_t       q;
  logic                   q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clr) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= ctl.wr_data;
    end
    q       <= mem[rd_addr];
    q_valid <= valid[rd_addr];
  end

  assign rd_data = q_valid ? q : '0;

endmodule

/* src/oxc_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oxc_seq
// Sequencer for load, slice copy, fill scan and child emission.
// ----------------------------------------------------------------------------
module oxc_seq #(
  parameter int MAX_CLIENTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  oxc_pkg::ncfg_t                 n_clients,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  oxc_pkg::client_t               parent_a_client,
  input  oxc_pkg::client_t               parent_b_client,
  input  oxc_pkg::slice_t                slice_start,
  input  oxc_pkg::slice_t                slice_end,
  output logic                           tour_wr_en,
  output logic [$clog2(MAX_CLIENTS)-1:0] tour_wr_addr,
  output oxc_pkg::tour_pair_t            tour_wr_data,
  output logic [$clog2(MAX_CLIENTS)-1:0] tour_rd_addr,
  input  oxc_pkg::tour_pair_t            tour_rd_data,
  output oxc_pkg::child_ctl_t            child_ctl,
  output logic [$clog2(MAX_CLIENTS)-1:0] child_wr_addr,
  output logic [$clog2(MAX_CLIENTS)-1:0] child_rd_addr,
  input  oxc_pkg::client_t               child_rd_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output oxc_pkg::client_t               out_client,
  output logic                           out_last
);

  localparam int AW  = $clog2(MAX_CLIENTS);
  localparam int CW  = $clog2(MAX_CLIENTS + 1);
  localparam int NW  = (CW > oxc_pkg::CLIENT_W) ? CW : oxc_pkg::CLIENT_W;
  localparam int IXW = (AW > oxc_pkg::CLIENT_W) ? AW : oxc_pkg::CLIENT_W;

  typedef enum logic [2:0] {
    ST_LOAD, ST_PREP, ST_COPY_RD, ST_COPY_WR, ST_FILL_RD, ST_FILL_WR, ST_EMIT_RD, ST_EMIT_OUT
  } state_t;

  state_t                 state;
  logic [AW-1:0]          lc;
  oxc_pkg::slice_t        s_reg;
  oxc_pkg::slice_t        e_reg;
  logic [AW-1:0]          ec;
  logic [AW-1:0]          p;
  logic [AW-1:0]          j;
  logic [AW-1:0]          pos;
  logic [AW-1:0]          k;
  logic [CW-1:0]          written;
  logic [CW-1:0]          cnt;
  logic [MAX_CLIENTS-1:0] marks;

  logic [NW-1:0]  n_ext;
  logic [CW-1:0]  n_eff;
  logic [CW-1:0]  n_last;
  logic [AW-1:0]  n_last_ix;
  logic [CW-1:0]  lc_inc;
  logic [NW-1:0]  s_ext;
  logic [NW-1:0]  e_ext;
  logic [AW-1:0]  sc_w;
  logic [AW-1:0]  ec_w;
  logic [IXW-1:0] a_ix_full;
  logic [IXW-1:0] b_ix_full;
  logic [AW-1:0]  a_idx;
  logic [AW-1:0]  b_idx;
  logic           a_in;
  logic           b_in;
  logic           b_marked;
  logic           fill_take;
  logic           out_free;
  oxc_pkg::client_t a_q;
  oxc_pkg::client_t b_q;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x,
                                             input logic [AW-1:0] last);
    return (x == last) ? '0 : x + 1'b1;
  endfunction

  assign n_ext     = NW'(n_clients);
  assign n_eff     = (n_ext < NW'(2)) ? CW'(2) :
                     (n_ext > NW'(MAX_CLIENTS)) ? CW'(MAX_CLIENTS) : CW'(n_ext);
  assign n_last    = n_eff - CW'(1);
  assign n_last_ix = n_last[AW-1:0];
  assign lc_inc    = CW'(lc) + CW'(1);

  assign s_ext = NW'(s_reg);
  assign e_ext = NW'(e_reg);
  assign sc_w  = (s_ext >= NW'(n_eff)) ? n_last_ix : s_ext[AW-1:0];
  assign ec_w  = (e_ext >= NW'(n_eff)) ? n_last_ix : e_ext[AW-1:0];

  assign a_q = tour_rd_data.a;
  assign b_q = tour_rd_data.b;

  assign a_in      = (a_q != '0) && (NW'(a_q) <= NW'(MAX_CLIENTS));
  assign b_in      = (b_q != '0) && (NW'(b_q) <= NW'(MAX_CLIENTS));
  assign a_ix_full = IXW'(a_q) - IXW'(1);
  assign b_ix_full = IXW'(b_q) - IXW'(1);
  assign a_idx     = a_ix_full[AW-1:0];
  assign b_idx     = b_ix_full[AW-1:0];
  assign b_marked  = b_in && marks[b_idx];
  assign fill_take = !b_marked && (written < n_eff);
  assign out_free  = !out_valid || out_ready;

  assign in_ready       = (state == ST_LOAD);
  assign tour_wr_en     = in_valid && in_ready;
  assign tour_wr_addr   = lc;
  assign tour_wr_data.a = parent_a_client;
  assign tour_wr_data.b = parent_b_client;
  assign tour_rd_addr   = (state == ST_FILL_RD) ? j : p;

  assign child_ctl.clr     = (state == ST_PREP);
  assign child_ctl.wr_en   = (state == ST_COPY_WR) || ((state == ST_FILL_WR) && fill_take);
  assign child_ctl.wr_data = (state == ST_COPY_WR) ? a_q : b_q;
  assign child_wr_addr     = (state == ST_COPY_WR) ? p : pos;
  assign child_rd_addr     = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      lc        <= '0;
      s_reg     <= '0;
      e_reg     <= '0;
      marks     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_EMIT_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_valid) begin
            if (lc == '0) begin
              s_reg <= slice_start;
              e_reg <= slice_end;
            end
            if (lc_inc >= n_eff) begin
              lc    <= '0;
              state <= ST_PREP;
            end else begin
              lc <= lc + 1'b1;
            end
          end
        end
        ST_PREP: begin
          marks   <= '0;
          p       <= sc_w;
          ec      <= ec_w;
          written <= '0;
          state   <= ST_COPY_RD;
        end
        ST_COPY_RD: begin
          state <= ST_COPY_WR;
        end
        ST_COPY_WR: begin
          if (a_in) begin
            marks[a_idx] <= 1'b1;
          end
          written <= written + CW'(1);
          if (p == ec) begin
            j     <= wrap_inc(ec, n_last_ix);
            pos   <= wrap_inc(ec, n_last_ix);
            cnt   <= '0;
            state <= ST_FILL_RD;
          end else begin
            p     <= wrap_inc(p, n_last_ix);
            state <= ST_COPY_RD;
          end
        end
        ST_FILL_RD: begin
          state <= ST_FILL_WR;
        end
        ST_FILL_WR: begin
          if (fill_take) begin
            pos     <= wrap_inc(pos, n_last_ix);
            written <= written + CW'(1);
          end
          cnt <= cnt + CW'(1);
          if (cnt == n_last) begin
            k     <= '0;
            state <= ST_EMIT_RD;
          end else begin
            j     <= wrap_inc(j, n_last_ix);
            state <= ST_FILL_RD;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_client <= child_rd_data;
            out_last   <= (k == n_last_ix);
            if (k == n_last_ix) begin
              state <= ST_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

/* src/ordered_crossover_permutation_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_crossover_permutation_top
// Ordered crossover of two parent tours into one child tour.
// ----------------------------------------------------------------------------
//  Channel  Signals                        Contents
//  cfg      cfg_valid/cfg_ready/cfg_data   n_clients
//  s        s_tvalid/s_tready/s_tdata      one position of both parents
//  m        m_tvalid/m_tready/m_tdata      one child position, tlast on the final
//
// Loading accepts one transaction per cycle. After the n-th load the run has a
// setup state, a read and a write state per copied slice position and per
// scanned position of the second parent, then a read and an output state per
// emitted result, the read states covering the registered read of the tour and
// child memories. A stalled output holds the emission; a pending final result
// does not block loading. Reset restores n_clients to 64 and returns to loading.
// ----------------------------------------------------------------------------
module ordered_crossover_permutation_top #(
  parameter int MAX_CLIENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // parent_a_client[6:0], parent_b_client[13:7], slice_start[19:14],
  // slice_end[25:20], zero fill [31:26]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // child_client[6:0], zero fill [7]
  output logic [7:0]  m_tdata,
  output logic        m_tlast
);

  localparam int AW = $clog2(MAX_CLIENTS);

  oxc_pkg::ncfg_t      n_clients;
  logic                tour_wr_en;
  logic [AW-1:0]       tour_wr_addr;
  oxc_pkg::tour_pair_t tour_wr_data;
  logic [AW-1:0]       tour_rd_addr;
  oxc_pkg::tour_pair_t tour_rd_data;
  oxc_pkg::child_ctl_t child_ctl;
  logic [AW-1:0]       child_wr_addr;
  logic [AW-1:0]       child_rd_addr;
  oxc_pkg::client_t    child_rd_data;
  oxc_pkg::client_t    out_client;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_clients <= oxc_pkg::N_CLIENTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      n_clients <= cfg_data;
    end
  end

  oxc_seq #(
    .MAX_CLIENTS(MAX_CLIENTS)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .n_clients       (n_clients),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .parent_a_client (s_tdata[6:0]),
    .parent_b_client (s_tdata[13:7]),
    .slice_start     (s_tdata[19:14]),
    .slice_end       (s_tdata[25:20]),
    .tour_wr_en      (tour_wr_en),
    .tour_wr_addr    (tour_wr_addr),
    .tour_wr_data    (tour_wr_data),
    .tour_rd_addr    (tour_rd_addr),
    .tour_rd_data    (tour_rd_data),
    .child_ctl       (child_ctl),
    .child_wr_addr   (child_wr_addr),
    .child_rd_addr   (child_rd_addr),
    .child_rd_data   (child_rd_data),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_client      (out_client),
    .out_last        (m_tlast)
  );

  oxc_tour_mem #(
    .MAX_CLIENTS(MAX_CLIENTS)
  ) u_tour_mem (
    .clk     (clk),
    .wr_en   (tour_wr_en),
    .wr_addr (tour_wr_addr),
    .wr_data (tour_wr_data),
    .rd_addr (tour_rd_addr),
    .rd_data (tour_rd_data)
  );

  oxc_child_mem #(
    .MAX_CLIENTS(MAX_CLIENTS)
  ) u_child_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (child_ctl),
    .wr_addr (child_wr_addr),
    .rd_addr (child_rd_addr),
    .rd_data (child_rd_data)
  );

  assign m_tdata = {1'b0, out_client};

`ifndef NO_ASSERTIONS
  // While loading, only the final result of the previous run may still wait.
  a_pending_is_last: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast)
    else $error("non-final result pending while loading");

  // A result that waits for the receiver keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");
`endif

endmodule

/* tb/sv/ordered_crossover_permutation_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_crossover_permutation_top_test
// Self-checking bench for the ordered crossover block.
//
// Parent tours are loaded one position per transaction. Short hand-picked
// tours cover the edge cases first: slice bounds past the tour, a wrapped
// slice, a slice that covers the whole tour, clients that are out of range
// or repeated, fill overflow, and empty slots. Random tours follow, mostly
// proper permutations with some noise. The tour length changes between
// phases while the block is idle. A scoreboard rebuilds each child tour and
// checks every emitted position in order. Both sides stall at random, with
// one long output stall and one input pause until the output has drained.
// ----------------------------------------------------------------------------
module ordered_crossover_permutation_top_test;

  localparam int MAX_CLIENTS = 64;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    oxc_pkg::client_t client;
    logic             last;
  } child_entry_t;

  class ox_child_scoreboard;
    oxc_pkg::ncfg_t   n_cfg;
    oxc_pkg::client_t tour_a [MAX_CLIENTS];
    oxc_pkg::client_t tour_b [MAX_CLIENTS];
    int unsigned      loaded;
    oxc_pkg::slice_t  slice_lo;
    oxc_pkg::slice_t  slice_hi;
    child_entry_t     pending_children [$];
    int unsigned      mismatches;

    function new();
      n_cfg = oxc_pkg::N_CLIENTS_RESET;
      loaded = 0;
      slice_lo = '0;
      slice_hi = '0;
      mismatches = 0;
    endfunction

    function int unsigned eff_n();
      int unsigned n;
      n = 32'(n_cfg);
      if (n < 2) n = 2;
      if (n > MAX_CLIENTS) n = MAX_CLIENTS;
      return n;
    endfunction

    function void set_n(oxc_pkg::ncfg_t value);
      n_cfg = value;
    endfunction

    function int unsigned outstanding();
      return pending_children.size();
    endfunction

    // Takes one accepted load and, on the last position of a tour, predicts
    // the whole child tour.
    function void note_load(oxc_pkg::client_t a, oxc_pkg::client_t b,
                            oxc_pkg::slice_t s, oxc_pkg::slice_t e);
      int unsigned      n, lo, hi, len, i, p, pos, written;
      oxc_pkg::client_t c;
      bit               marked [MAX_CLIENTS];
      oxc_pkg::client_t child [MAX_CLIENTS];
      child_entry_t     entry;
      n = eff_n();
      if (loaded >= MAX_CLIENTS) loaded = 0;
      if (loaded == 0) begin
        slice_lo = s;
        slice_hi = e;
      end
      tour_a[loaded] = a;
      tour_b[loaded] = b;
      loaded++;
      if (loaded < n) return;
      loaded = 0;
      marked = '{default: 1'b0};
      child = '{default: '0};
      lo = (32'(slice_lo) >= n) ? n - 1 : 32'(slice_lo);
      hi = (32'(slice_hi) >= n) ? n - 1 : 32'(slice_hi);
      len = ((hi + n - lo) % n) + 1;
      for (i = 0; i < len; i++) begin
        p = (lo + i) % n;
        child[p] = tour_a[p];
        if (tour_a[p] >= 1 && tour_a[p] <= MAX_CLIENTS)
          marked[tour_a[p] - 1] = 1'b1;
      end
      pos = lo + len;
      written = len;
      for (i = 1; i <= n; i++) begin
        c = tour_b[(hi + i) % n];
        if (!(c >= 1 && c <= MAX_CLIENTS && marked[c - 1]) && written < n) begin
          child[pos % n] = c;
          pos++;
          written++;
        end
      end
      for (i = 0; i < n; i++) begin
        entry.client = child[i];
        entry.last = (i == n - 1);
        pending_children.push_back(entry);
      end
    endfunction

    function void check_child(oxc_pkg::client_t client, logic last);
      child_entry_t want;
      if (pending_children.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected child entry client=%0d last=%0b", $time, client, last);
        mismatches++;
        return;
      end
      want = pending_children.pop_front();
      if (client !== want.client || last !== want.last) begin
        if (mismatches < 10)
          $display("%0t: child mismatch: expected client=%0d last=%0b, %s%0d last=%0b",
                   $time, want.client, want.last, "got client=", client, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  ox_child_scoreboard sb = new();

  int               src_idle = 10;
  int               dst_idle = 52;
  int               rx_hold = 0;
  oxc_pkg::client_t run_a [MAX_CLIENTS];
  oxc_pkg::client_t run_b [MAX_CLIENTS];
  int               phase_cfg [9] = '{3, 8, 1, 127, 4, 6, 2, 5, 3};
  int               phase_runs [9] = '{2, 1, 2, 1, 2, 1, 1, 1, 1};

  ordered_crossover_permutation_top #(
    .MAX_CLIENTS(MAX_CLIENTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: checks each transaction and decides the next ready.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (m_tvalid && m_tready) sb.check_child(m_tdata[6:0], m_tlast);
        if (rx_hold > 0) begin
          rx_hold--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= ($urandom_range(99) >= dst_idle);
        end
      end
    end
  end

  task automatic send_load(oxc_pkg::client_t a, oxc_pkg::client_t b,
                           oxc_pkg::slice_t s, oxc_pkg::slice_t e);
    if ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, e, s, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_load(a, b, s, e);
  endtask

  task automatic load_run(int n, oxc_pkg::slice_t s, oxc_pkg::slice_t e);
    for (int i = 0; i < n; i++) begin
      if (i == 0) send_load(run_a[i], run_b[i], s, e);
      else send_load(run_a[i], run_b[i], oxc_pkg::slice_t'($urandom),
                     oxc_pkg::slice_t'($urandom));
    end
  endtask

  task automatic load_directed(int n, oxc_pkg::client_t a [4], oxc_pkg::client_t b [4],
                               oxc_pkg::slice_t s, oxc_pkg::slice_t e);
    for (int i = 0; i < 4; i++) begin
      run_a[i] = a[i];
      run_b[i] = b[i];
    end
    load_run(n, s, e);
  endtask

  task automatic load_random_tour(int n);
    int               j;
    oxc_pkg::client_t t;
    oxc_pkg::slice_t  s;
    oxc_pkg::slice_t  e;
    bit               noisy;
    noisy = ($urandom_range(99) < 20);
    for (int i = 0; i < n; i++) begin
      run_a[i] = oxc_pkg::client_t'(i + 1);
      run_b[i] = oxc_pkg::client_t'(i + 1);
    end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = run_a[i]; run_a[i] = run_a[j]; run_a[j] = t;
      j = $urandom_range(0, i);
      t = run_b[i]; run_b[i] = run_b[j]; run_b[j] = t;
    end
    if (noisy) begin
      for (int i = 0; i < n; i++) begin
        run_a[i] = ($urandom_range(3) == 0) ? oxc_pkg::client_t'($urandom) :
                   oxc_pkg::client_t'($urandom_range(1, n));
        run_b[i] = ($urandom_range(3) == 0) ? oxc_pkg::client_t'($urandom) :
                   oxc_pkg::client_t'($urandom_range(1, n));
      end
    end
    s = ($urandom_range(99) < 20) ? oxc_pkg::slice_t'($urandom) :
        oxc_pkg::slice_t'($urandom_range(0, n - 1));
    e = ($urandom_range(99) < 20) ? oxc_pkg::slice_t'($urandom) :
        oxc_pkg::slice_t'($urandom_range(0, n - 1));
    load_run(n, s, e);
  endtask

  task automatic drain_children();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_clients(oxc_pkg::ncfg_t value);
    drain_children();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_n(value);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A length of zero acts as two.
    write_clients(oxc_pkg::ncfg_t'(0));
    load_directed(2, '{1, 2, 0, 0}, '{2, 1, 0, 0}, 0, 0);
    load_directed(2, '{2, 1, 0, 0}, '{1, 2, 0, 0}, 63, 63);
    load_directed(2, '{1, 2, 0, 0}, '{2, 1, 0, 0}, 1, 0);

    write_clients(oxc_pkg::ncfg_t'(4));
    load_directed(4, '{3, 1, 4, 2}, '{2, 4, 1, 3}, 1, 2);
    load_directed(4, '{0, 127, 64, 5}, '{64, 0, 127, 1}, 3, 0);
    load_directed(4, '{2, 2, 3, 3}, '{1, 1, 1, 1}, 63, 63);
    load_directed(4, '{1, 2, 3, 4}, '{1, 1, 1, 1}, 0, 0);

    for (int ph = 0; ph < 9; ph++) begin
      src_idle = (ph < 3) ? 10 : (ph < 6) ? 52 : 0;
      dst_idle = (ph < 3) ? 52 : (ph < 6) ? 10 : 0;
      write_clients(oxc_pkg::ncfg_t'(phase_cfg[ph]));
      if (ph == 0) rx_hold = 300;
      for (int r = 0; r < phase_runs[ph]; r++) begin
        if (ph == 4 && r == 1) begin
          s_tvalid <= 1'b0;
          while (sb.outstanding() != 0) @(posedge clk);
        end
        load_random_tour(sb.eff_n());
      end
    end

    drain_children();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
src/oxc_pkg.sv
src/oxc_tour_mem.sv
src/oxc_child_mem.sv
src/oxc_seq.sv
src/ordered_crossover_permutation_top.sv
tb/sv/ordered_crossover_permutation_top_test.sv
